[sv/bbc_pkg.sv]
// Shared types and constants for the bracket balance checker.
// Used by bbc_scanner, bbc_stack and bracket_balance_checker.
`default_nettype none

package bbc_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int LINE_W      = 32;
  localparam int CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [CHAR_W-1:0] CH_STAR      = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_RPAREN    = 8'h29;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_BRACE   = 2'd1,
    KIND_BRACKET = 2'd2,
    KIND_PAREN   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_RUNNING  = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_BADBRACE = 3'd2,
    ST_BADBRACK = 3'd3,
    ST_BADPAREN = 3'd4,
    ST_UNCLOSED = 3'd5,
    ST_BALANCED = 3'd6
  } status_t;

  // Bracket event decoded from one source byte.
  typedef struct packed {
    logic  newline;
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } scan_evt_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    kind_t kind;
  } stk_ctrl_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    kind_t              top;
    logic               full;
    logic [DEPTH_W-1:0] depth_next;
    kind_t              top_next;
  } stk_stat_t;

endpackage

`default_nettype wire

[sv/bbc_scanner.sv]
// Lexical mode tracker: string, char constant and comment modes.
// Decodes each byte into a bracket event. Depends on bbc_pkg.
`default_nettype none

module bbc_scanner (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic [bbc_pkg::CHAR_W-1:0] char_code,
  output bbc_pkg::scan_evt_t             evt
);

  logic [bbc_pkg::CHAR_W-1:0] prev_char;
  logic in_string, in_char, in_comment;
  logic in_string_next, in_char_next, in_comment_next;
  logic dbl_bs;
  logic [bbc_pkg::CHAR_W-1:0] p, c;

  always_comb begin
    // a doubled backslash inside a literal escapes nothing
    dbl_bs = (in_string || in_char) && prev_char == bbc_pkg::CH_BACKSLASH &&
             char_code == bbc_pkg::CH_BACKSLASH;
    p = dbl_bs ? '0 : prev_char;
    c = dbl_bs ? '0 : char_code;

    in_string_next  = in_string;
    in_char_next    = in_char;
    in_comment_next = in_comment;
    if (in_string) begin
      if (p != bbc_pkg::CH_BACKSLASH && c == bbc_pkg::CH_DQUOTE) in_string_next = 1'b0;
    end else if (in_char) begin
      if (p != bbc_pkg::CH_BACKSLASH && c == bbc_pkg::CH_SQUOTE) in_char_next = 1'b0;
    end else if (in_comment) begin
      if (p == bbc_pkg::CH_STAR && c == bbc_pkg::CH_SLASH) in_comment_next = 1'b0;
    end else if (p == bbc_pkg::CH_SLASH && c == bbc_pkg::CH_STAR) begin
      in_comment_next = 1'b1;
    end else if (c == bbc_pkg::CH_DQUOTE) begin
      in_string_next = 1'b1;
    end else if (c == bbc_pkg::CH_SQUOTE) begin
      in_char_next = 1'b1;
    end

    evt          = '0;
    evt.kind     = bbc_pkg::KIND_NONE;
    evt.newline  = (c == bbc_pkg::CH_NEWLINE);
    if (!evt.newline && !(in_string_next || in_char_next || in_comment_next)) begin
      case (c)
        bbc_pkg::CH_LBRACE: begin
          evt.is_open = 1'b1;
          evt.kind    = bbc_pkg::KIND_BRACE;
        end
        bbc_pkg::CH_LBRACKET: begin
          evt.is_open = 1'b1;
          evt.kind    = bbc_pkg::KIND_BRACKET;
        end
        bbc_pkg::CH_LPAREN: begin
          evt.is_open = 1'b1;
          evt.kind    = bbc_pkg::KIND_PAREN;
        end
        bbc_pkg::CH_RBRACE: begin
          evt.is_close = 1'b1;
          evt.kind     = bbc_pkg::KIND_BRACE;
        end
        bbc_pkg::CH_RBRACKET: begin
          evt.is_close = 1'b1;
          evt.kind     = bbc_pkg::KIND_BRACKET;
        end
        bbc_pkg::CH_RPAREN: begin
          evt.is_close = 1'b1;
          evt.kind     = bbc_pkg::KIND_PAREN;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char  <= '0;
      in_string  <= 1'b0;
      in_char    <= 1'b0;
      in_comment <= 1'b0;
    end else if (en) begin
      prev_char  <= c;
      in_string  <= in_string_next;
      in_char    <= in_char_next;
      in_comment <= in_comment_next;
    end
  end

endmodule

`default_nettype wire

[sv/bbc_stack.sv]
// Opener stack: memory with the top entry cached in a register and the
// entry below it prefetched every cycle. Depends on bbc_pkg.
`default_nettype none

module bbc_stack (
  input  wire logic          clk,
  input  wire logic          rst,
  input  bbc_pkg::stk_ctrl_t ctrl,
  output bbc_pkg::stk_stat_t stat
);

  logic [1:0] mem [bbc_pkg::STACK_DEPTH];

  logic [bbc_pkg::DEPTH_W-1:0] depth, depth_next;
  bbc_pkg::kind_t              top_r, top_r_next;
  logic [1:0]                  below;
  logic [bbc_pkg::DEPTH_W-1:0] rd_sum;
  logic [bbc_pkg::ADDR_W-1:0]  rd_addr;

  always_comb begin
    depth_next = depth;
    top_r_next = top_r;
    if (ctrl.push) begin
      depth_next = depth + bbc_pkg::DEPTH_W'(1);
      top_r_next = ctrl.kind;
    end else if (ctrl.pop) begin
      depth_next = depth - bbc_pkg::DEPTH_W'(1);
      top_r_next = bbc_pkg::kind_t'(below);
    end
    // keep mem[depth-2] ready for the next pop
    rd_sum  = depth_next - bbc_pkg::DEPTH_W'(2);
    rd_addr = rd_sum[bbc_pkg::ADDR_W-1:0];

    stat.depth      = depth;
    stat.top        = (depth == '0) ? bbc_pkg::KIND_NONE : top_r;
    stat.full       = (depth == bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH));
    stat.depth_next = depth_next;
    stat.top_next   = (depth_next == '0) ? bbc_pkg::KIND_NONE : top_r_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      top_r <= bbc_pkg::KIND_NONE;
    end else begin
      depth <= depth_next;
      top_r <= top_r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) mem[depth[bbc_pkg::ADDR_W-1:0]] <= ctrl.kind;
    below <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[sv/bracket_balance_checker.sv]
// Top level of the bracket balance checker: stream ports, error and line
// tracking, result register. Depends on bbc_pkg, bbc_scanner, bbc_stack.
//
// Takes one byte of C source per transfer and returns one result per
// transfer, in the cycle after it is accepted; a new byte is accepted every
// cycle as long as the result register is free or being drained. Each byte
// makes at most one push or pop on a 1024 x 2 opener memory; the top entry
// lives in a register and the entry below it is read ahead each cycle, so
// pops back to back need no wait. The stack needs no clearing after reset.
// A transfer with tlast set ends the text and yields status unclosed or
// balanced. Any nonzero status is sticky until reset.
`default_nettype none

module bracket_balance_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] char_code
  input  wire logic        s_tlast,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata    // [2:0] status, [34:3] line_number,
                                      // [36:35] open_kind, [47:37] nesting_depth
);

  bbc_pkg::status_t            err, err_next;
  logic [bbc_pkg::LINE_W-1:0]  line_cnt, line_next;
  bbc_pkg::scan_evt_t          evt;
  bbc_pkg::stk_ctrl_t          stk_ctrl;
  bbc_pkg::stk_stat_t          stk_stat;
  logic                        s_xfer, step;

  assign s_tready = !m_tvalid || m_tready;
  assign s_xfer   = s_tvalid && s_tready;
  assign step     = s_xfer && (err == bbc_pkg::ST_RUNNING);

  bbc_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .en        (step && !s_tlast),
    .char_code (s_tdata),
    .evt       (evt)
  );

  always_comb begin
    err_next      = err;
    line_next     = line_cnt;
    stk_ctrl      = '0;
    stk_ctrl.kind = evt.kind;
    if (step) begin
      if (s_tlast) begin
        err_next = (stk_stat.depth != '0) ? bbc_pkg::ST_UNCLOSED : bbc_pkg::ST_BALANCED;
      end else if (evt.newline) begin
        if (line_cnt != '1) line_next = line_cnt + bbc_pkg::LINE_W'(1);
      end else if (evt.is_open) begin
        if (stk_stat.full) err_next = bbc_pkg::ST_OVERFLOW;
        else stk_ctrl.push = 1'b1;
      end else if (evt.is_close) begin
        if (stk_stat.depth != '0 && stk_stat.top == evt.kind) begin
          stk_ctrl.pop = 1'b1;
        end else begin
          case (evt.kind)
            bbc_pkg::KIND_BRACE:   err_next = bbc_pkg::ST_BADBRACE;
            bbc_pkg::KIND_BRACKET: err_next = bbc_pkg::ST_BADBRACK;
            default:               err_next = bbc_pkg::ST_BADPAREN;
          endcase
        end
      end
    end
  end

  bbc_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .ctrl (stk_ctrl),
    .stat (stk_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      err      <= bbc_pkg::ST_RUNNING;
      line_cnt <= bbc_pkg::LINE_W'(1);
      m_tvalid <= 1'b0;
    end else begin
      err      <= err_next;
      line_cnt <= line_next;
      if (s_xfer) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      m_tdata <= {stk_stat.depth_next, stk_stat.top_next, line_next, err_next};
    end
  end

  // sticky status never changes once set
  assert property (@(posedge clk) disable iff (rst)
    err != bbc_pkg::ST_RUNNING |=> err == $past(err))
    else $error("status changed after it was set");

  // after an error or end marker the stack is frozen
  assert property (@(posedge clk) disable iff (rst)
    err != bbc_pkg::ST_RUNNING |=> $stable(stk_stat.depth) && $stable(line_cnt))
    else $error("stack or line count moved after end");

  // reported opener kind is none exactly when nothing is nested
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[36:35] == bbc_pkg::KIND_NONE) == (m_tdata[47:37] == 11'd0)))
    else $error("open_kind disagrees with nesting_depth");

  assert property (@(posedge clk) disable iff (rst)
    stk_stat.depth <= bbc_pkg::DEPTH_W'(bbc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

endmodule

`default_nettype wire
